FILE: rtl/mhr_pkg.sv
// Shared types and constants for the message history ring.
package mhr_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TEXT_MAX_DEF = 64;

    localparam int LEN_W       = 7;
    localparam int OFFSET_W    = 16;
    localparam int HELD_W      = 5;
    localparam int SEQ_W       = 32;
    localparam int NODE_W      = 32;
    localparam int CHAN_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int DECL_LEN_W  = 16;
    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 160;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        KIND_PUBLISH = 1'b0,
        KIND_READ    = 1'b1
    } t_kind;

    // Classified request as it waits between front and back.
    typedef struct packed {
        t_kind                 kind;
        logic                  last;
        logic [NODE_W-1:0]     from_node;
        logic [NODE_W-1:0]     to_node;
        logic [CHAN_W-1:0]     channel;
        logic [LEN_W-1:0]      length;
        logic [BYTE_W-1:0]     text_byte;
        logic [OFFSET_W-1:0]   read_offset;
    } t_item;

    // Header as kept in the header memory.
    typedef struct packed {
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] receiver;
        logic [CHAN_W-1:0] channel;
        logic [LEN_W-1:0]  length;
    } t_hdr;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] receiver;
        logic [CHAN_W-1:0] chan_out;
        logic [LEN_W-1:0]  stored_length;
        logic [SEQ_W-1:0]  entry_seq;
        logic [BYTE_W-1:0] byte_out;
        logic              run_last;
        logic [HELD_W-1:0] entries_held;
        logic [SEQ_W-1:0]  newest_seq;
    } t_result;

endpackage

FILE: rtl/mhr_ram.sv
// Generic single-write, single-read memory with registered read data.
module mhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while not enabled
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mhr_front.sv
// Request intake: unpacks and classifies input transfers into a short queue.
module mhr_front import mhr_pkg::*; #(
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 s_axis_tuser,
    output logic                 o_valid,
    output t_item                o_item,
    input  logic                 i_pop
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]    r_wr;
    logic [QAW-1:0]    r_rd;
    logic [QCW-1:0]    r_cnt;
    t_item             n_item;
    logic [DECL_LEN_W-1:0] decl_len;
    logic              push;
    logic              pop;

    always_comb begin
        decl_len           = s_axis_tdata[87:72];
        n_item.kind        = t_kind'(s_axis_tuser);
        n_item.last        = s_axis_tlast;
        n_item.from_node   = s_axis_tdata[31:0];
        n_item.to_node     = s_axis_tdata[63:32];
        n_item.channel     = s_axis_tdata[71:64];
        // clamp declared length to the text slot size
        n_item.length      = (decl_len > DECL_LEN_W'(TEXT_MAX)) ?
                             LEN_W'(TEXT_MAX) : decl_len[LEN_W-1:0];
        n_item.text_byte   = s_axis_tdata[95:88];
        n_item.read_offset = s_axis_tdata[111:96];
    end

    assign s_axis_tready = (r_cnt != QCW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_valid       = (r_cnt != '0);
    assign pop           = i_pop && o_valid;
    assign o_item        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mhr_back.sv
// Request execution: ring state, publish writes and read runs into the output register.
module mhr_back import mhr_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    output t_result o_res,
    input  logic    i_out_ready
);

    localparam int HW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TD = CAPACITY * TEXT_MAX;
    localparam int AW = $clog2(TD);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state;
    logic [HW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [SEQ_W-1:0]  r_latest;
    logic [LEN_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_len;
    logic              r_active;
    logic [AW-1:0]     r_base;
    logic [LEN_W-1:0]  r_k;
    logic              r_out_valid;
    t_result           r_res;

    t_result           n_res;
    logic              slot_free;
    logic              is_pub;
    logic              is_rd;
    logic              rd_found;
    logic              pub_first;
    logic [LEN_W-1:0]  pub_len;
    logic [LEN_W-1:0]  pub_pos;
    logic [HW:0]       idx_sum;
    logic [HW-1:0]     rd_idx;
    logic [AW-1:0]     head_base;
    logic [AW-1:0]     idx_base;
    logic              start_rd;
    logic              miss_emit;
    logic              run_emit;
    logic              run_end;
    t_hdr              hdr_wdata;
    t_hdr              hdr_rdata;
    logic [SEQ_W-1:0]  seq_rdata;
    logic [BYTE_W-1:0] txt_rdata;
    logic              txt_we;
    logic [AW-1:0]     txt_waddr;
    logic              txt_re;
    logic [AW-1:0]     txt_raddr;
    logic              seq_we;
    logic              hdr_we;

    always_comb begin
        slot_free = !r_out_valid || i_out_ready;
        is_pub    = i_valid && (r_state == ST_IDLE) && (i_item.kind == KIND_PUBLISH);
        is_rd     = i_valid && (r_state == ST_IDLE) && (i_item.kind == KIND_READ);
        rd_found  = i_item.read_offset < OFFSET_W'(r_count);

        // slot of the entry read_offset places behind the newest
        idx_sum = (HW + 1)'(r_head) + (HW + 1)'(CAPACITY - 1)
                - (HW + 1)'(i_item.read_offset[HW-1:0]);
        if (idx_sum >= (HW + 1)'(CAPACITY)) begin
            idx_sum = idx_sum - (HW + 1)'(CAPACITY);
        end
        rd_idx    = idx_sum[HW-1:0];
        head_base = AW'(r_head) * AW'(TEXT_MAX);
        idx_base  = AW'(rd_idx) * AW'(TEXT_MAX);

        pub_first = !r_active;
        pub_len   = pub_first ? i_item.length : r_len;
        pub_pos   = pub_first ? '0 : r_pos;

        hdr_we    = is_pub && pub_first;
        hdr_wdata = '{sender: i_item.from_node, receiver: i_item.to_node,
                      channel: i_item.channel, length: i_item.length};
        txt_we    = is_pub && (pub_pos < pub_len);
        txt_waddr = head_base + AW'(pub_pos);
        seq_we    = is_pub && i_item.last;

        start_rd  = is_rd && rd_found;
        miss_emit = is_rd && !rd_found && slot_free;
        run_emit  = (r_state == ST_RUN) && slot_free;
        run_end   = (hdr_rdata.length == '0) || ((r_k + 1'b1) == hdr_rdata.length);
        txt_re    = start_rd || (run_emit && !run_end);
        txt_raddr = start_rd ? idx_base : r_base + AW'(r_k) + AW'(1);

        o_pop = is_pub || start_rd || miss_emit;

        n_res.found         = run_emit;
        n_res.sender        = run_emit ? hdr_rdata.sender : '0;
        n_res.receiver      = run_emit ? hdr_rdata.receiver : '0;
        n_res.chan_out      = run_emit ? hdr_rdata.channel : '0;
        n_res.stored_length = run_emit ? hdr_rdata.length : '0;
        n_res.entry_seq     = run_emit ? seq_rdata : '0;
        n_res.byte_out      = (run_emit && hdr_rdata.length != '0) ? txt_rdata : '0;
        n_res.run_last      = run_emit ? run_end : 1'b1;
        n_res.entries_held  = HELD_W'(r_count);
        n_res.newest_seq    = r_latest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_latest    <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_active    <= 1'b0;
            r_base      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            if (is_pub) begin
                if (pub_first) begin
                    r_len <= i_item.length;
                end
                if (i_item.last) begin
                    r_latest <= r_latest + 1'b1;
                    r_head   <= (r_head == HW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
                    if (r_count != CW'(CAPACITY)) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_pos    <= '0;
                    r_active <= 1'b0;
                end else begin
                    // saturate the position at the slot size
                    r_pos    <= (pub_pos < LEN_W'(TEXT_MAX)) ? pub_pos + 1'b1 : pub_pos;
                    r_active <= 1'b1;
                end
            end

            if (start_rd) begin
                r_state <= ST_RUN;
                r_base  <= idx_base;
                r_k     <= '0;
            end else if (run_emit) begin
                if (run_end) begin
                    r_state <= ST_IDLE;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end

            if (run_emit || miss_emit) begin
                r_out_valid <= 1'b1;
                r_res       <= n_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    mhr_ram #(.WIDTH($bits(t_hdr)), .DEPTH(CAPACITY)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (r_head),
        .i_wdata (hdr_wdata),
        .i_re    (start_rd),
        .i_raddr (rd_idx),
        .o_rdata (hdr_rdata)
    );

    mhr_ram #(.WIDTH(SEQ_W), .DEPTH(CAPACITY)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (seq_we),
        .i_waddr (r_head),
        .i_wdata (r_latest + 1'b1),
        .i_re    (start_rd),
        .i_raddr (rd_idx),
        .o_rdata (seq_rdata)
    );

    mhr_ram #(.WIDTH(BYTE_W), .DEPTH(TD)) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_waddr),
        .i_wdata (i_item.text_byte),
        .i_re    (txt_re),
        .i_raddr (txt_raddr),
        .o_rdata (txt_rdata)
    );

endmodule

FILE: rtl/message_history_ring.sv
// Top level of the message history ring: ports, intake queue and execution back end.
//
// Keeps the last CAPACITY published messages, overwriting the oldest.
// Slave stream: tuser = request kind (0 publish, 1 read), tlast ends a publish run.
// A publish run is one transfer per text byte; the first latches the header,
// the tlast transfer assigns the next sequence number and advances the ring.
// A read transfer returns the entry read_offset places behind the newest as
// one master transfer per stored text byte (one if the text is empty) with
// tlast on the final one, or a single not-found transfer with tuser low.
// Requests pass a two-entry queue before execution. A publish item is written
// as it leaves the queue; a read first addresses the memories and then
// delivers one result per cycle while the master side accepts, so a run
// occupies the back end, during which later requests wait in the queue.
// When the master side stalls, the output register holds its result and the
// run pauses; publish items still execute as long as no read is in progress.
// Reset empties the ring, the queue and the output register; stored entries
// are not cleared and are unreachable until written again.
module message_history_ring import mhr_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // from_node, to_node, channel, text_length, text_byte, read_offset
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    // req_type
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sender, receiver, chan_out, stored_length, entry_seq, byte_out,
    // entries_held, newest_seq, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    // found
    output logic                 m_axis_tuser
);

    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    t_result res;

    mhr_front #(.TEXT_MAX(TEXT_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    mhr_back #(.CAPACITY(CAPACITY), .TEXT_MAX(TEXT_MAX)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_res       (res),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, res.newest_seq, res.entries_held, res.byte_out,
                           res.entry_seq, res.stored_length, res.chan_out,
                           res.receiver, res.sender};
    assign m_axis_tlast = res.run_last;
    assign m_axis_tuser = res.found;

endmodule
